// File: hw/rtl/ecpas_pkg.sv
// ecpas_pkg: shared types, constants and modular helpers for the affine point add/sub block
// no dependencies
package ecpas_pkg;

    localparam int FB = 32;
    localparam int CFG_IDX_W = 1;
    localparam logic [FB-1:0] MOD_RST = FB'(23);
    localparam logic [FB-1:0] COEFF_RST = FB'(1);

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF   = 1'b1;

    typedef enum logic [1:0] {
        OP_MUL = 2'b01,
        OP_DIV = 2'b10
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sts;

    function automatic logic [FB-1:0] add_mod(input logic [FB-1:0] x, input logic [FB-1:0] y,
                                              input logic [FB-1:0] p);
        logic [FB:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p}) s = s - {1'b0, p};
        return s[FB-1:0];
    endfunction

    function automatic logic [FB-1:0] sub_mod(input logic [FB-1:0] x, input logic [FB-1:0] y,
                                              input logic [FB-1:0] p);
        logic [FB-1:0] s;
        if (x >= y) s = x - y;
        else        s = x + (p - y);
        return s;
    endfunction

endpackage

// File: hw/rtl/ecpas_unit.sv
// ecpas_unit: shared bit-serial unit, modular multiply (msb first) or restoring divide
// depends on ecpas_pkg
module ecpas_unit
    import ecpas_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_req          i_req,
    input  logic [FB-1:0] i_a,    // multiplicand or divisor
    input  logic [FB-1:0] i_b,    // multiplier or dividend
    input  logic [FB-1:0] i_p,
    output t_sts          o_sts,
    output logic [FB-1:0] o_res,  // product or remainder
    output logic [FB-1:0] o_quo
);
    localparam int CW = $clog2(FB);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    t_op           r_op, n_op;
    logic [FB-1:0] r_a, n_a;
    logic [FB-1:0] r_b, n_b;
    logic [FB:0]   r_acc, n_acc;

    logic [FB:0] w_d2, w_sum, w_t;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        w_d2   = {r_acc[FB-1:0], 1'b0};
        if (w_d2 >= {1'b0, i_p}) w_d2 = w_d2 - {1'b0, i_p};
        w_sum  = w_d2 + (r_b[FB-1] ? {1'b0, r_a} : '0);
        if (w_sum >= {1'b0, i_p}) w_sum = w_sum - {1'b0, i_p};
        w_t    = {r_acc[FB-1:0], r_b[FB-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(FB - 1);
            n_op   = i_req.op;
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    n_acc = w_sum;
                    n_b   = {r_b[FB-2:0], 1'b0};
                end
                OP_DIV: begin
                    if (w_t >= {1'b0, r_a}) begin
                        n_acc = w_t - {1'b0, r_a};
                        n_b   = {r_b[FB-2:0], 1'b1};
                    end else begin
                        n_acc = w_t;
                        n_b   = {r_b[FB-2:0], 1'b0};
                    end
                end
                default: n_acc = r_acc;
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
        end
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res      = r_acc[FB-1:0];
    assign o_quo      = r_b;

endmodule

// File: hw/rtl/ec_point_add_sub_affine.sv
// Affine point addition/subtraction over GF(p), one item at a time on a shared serial unit.
// Each item runs as a sequence of operations on the shared unit: five reductions, up to five
// multiplies, and a modular inverse by extended Euclid where every step is one divide plus
// one multiply. Input tready is high only while idle; one finished result may wait in the
// output register while the next item is taken. Configuration writes are always ready.
// depends on ecpas_pkg, ecpas_unit
module ec_point_add_sub_affine
    import ecpas_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [4*FB-1:0]  i_s_axis_tdata,  // first_x, first_y, second_x, second_y
    input  logic [2:0]       i_s_axis_tuser,  // command, first_inf, second_inf
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [2*FB-1:0]  o_m_axis_tdata,  // result_x, result_y
    output logic             o_m_axis_tuser,  // result_inf
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FB-1:0]    i_cfg_data
);
    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_RED  = 14'b00000000000010,
        S_NEG  = 14'b00000000000100,
        S_CLS  = 14'b00000000001000,
        S_SQ   = 14'b00000000010000,
        S_TRI  = 14'b00000000100000,
        S_DEN  = 14'b00000001000000,
        S_IDIV = 14'b00000010000000,
        S_IMUL = 14'b00000100000000,
        S_ICHK = 14'b00001000000000,
        S_LAM  = 14'b00010000000000,
        S_LSQ  = 14'b00100000000000,
        S_LY   = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    t_state        r_state, n_state;
    logic          r_wait, n_wait;
    logic [2:0]    r_k, n_k;
    logic [FB-1:0] r_mod, r_coeff;
    logic          r_cmd, n_cmd, r_inf1, n_inf1, r_inf2, n_inf2;
    logic [FB-1:0] r_x1, n_x1, r_y1, n_y1, r_x2, n_x2, r_y2, n_y2, r_a, n_a;
    logic [FB-1:0] r_num, n_num, r_den, n_den;
    logic [FB-1:0] r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1, r_q, n_q, r_nr, n_nr;
    logic [FB-1:0] r_x3, n_x3, r_y3, n_y3;
    logic          r_rinf, n_rinf;
    logic          r_mvalid, n_mvalid;
    logic [FB-1:0] r_ox, n_ox, r_oy, n_oy;
    logic          r_oinf, n_oinf;

    t_req          w_req;
    t_sts          w_sts;
    logic [FB-1:0] w_ua, w_ub, w_res, w_quo, w_tmp;

    ecpas_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_ua),
        .i_b     (w_ub),
        .i_p     (r_mod),
        .o_sts   (w_sts),
        .o_res   (w_res),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state = r_state; n_wait = r_wait; n_k = r_k;
        n_cmd = r_cmd; n_inf1 = r_inf1; n_inf2 = r_inf2;
        n_x1 = r_x1; n_y1 = r_y1; n_x2 = r_x2; n_y2 = r_y2; n_a = r_a;
        n_num = r_num; n_den = r_den;
        n_r0 = r_r0; n_r1 = r_r1; n_t0 = r_t0; n_t1 = r_t1; n_q = r_q; n_nr = r_nr;
        n_x3 = r_x3; n_y3 = r_y3; n_rinf = r_rinf;
        n_mvalid = r_mvalid; n_ox = r_ox; n_oy = r_oy; n_oinf = r_oinf;
        w_req.start = 1'b0; w_req.op = OP_MUL;
        w_ua = '0; w_ub = '0;
        w_tmp = '0;
        if (r_mvalid && i_m_axis_tready) n_mvalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_x1   = i_s_axis_tdata[FB-1:0];
                    n_y1   = i_s_axis_tdata[2*FB-1:FB];
                    n_x2   = i_s_axis_tdata[3*FB-1:2*FB];
                    n_y2   = i_s_axis_tdata[4*FB-1:3*FB];
                    n_a    = r_coeff;
                    n_cmd  = i_s_axis_tuser[0];
                    n_inf1 = i_s_axis_tuser[1];
                    n_inf2 = i_s_axis_tuser[2];
                    n_k    = '0;
                    n_wait = 1'b0;
                    n_x3   = '0; n_y3 = '0; n_rinf = 1'b1;
                    if (r_mod < FB'(3)) n_state = S_OUT;
                    else                n_state = S_RED;
                end
            end
            S_RED: begin
                w_ua = FB'(1);
                case (r_k)
                    3'd0:    w_ub = r_x1;
                    3'd1:    w_ub = r_y1;
                    3'd2:    w_ub = r_x2;
                    3'd3:    w_ub = r_y2;
                    default: w_ub = r_a;
                endcase
                if (!r_wait) begin
                    w_req.start = 1'b1; n_wait = 1'b1;
                end else if (w_sts.done) begin
                    n_wait = 1'b0;
                    case (r_k)
                        3'd0:    n_x1 = w_res;
                        3'd1:    n_y1 = w_res;
                        3'd2:    n_x2 = w_res;
                        3'd3:    n_y2 = w_res;
                        default: n_a  = w_res;
                    endcase
                    n_k = r_k + 3'd1;
                    if (r_k == 3'd4) n_state = S_NEG;
                end
            end
            S_NEG: begin
                if (r_cmd && r_y2 != '0) n_y2 = r_mod - r_y2;
                n_state = S_CLS;
            end
            S_CLS: begin
                w_tmp = (r_y2 == '0) ? '0 : r_mod - r_y2;
                n_rinf = 1'b0;
                n_state = S_OUT;
                if (r_inf1 && r_inf2) begin
                    n_rinf = 1'b1; n_x3 = '0; n_y3 = '0;
                end else if (r_inf1) begin
                    n_x3 = r_x2; n_y3 = r_y2;
                end else if (r_inf2) begin
                    n_x3 = r_x1; n_y3 = r_y1;
                end else if (r_x1 == r_x2 && r_y1 == w_tmp) begin
                    n_rinf = 1'b1; n_x3 = '0; n_y3 = '0;
                end else if (r_x1 != r_x2 || r_y1 != r_y2) begin
                    n_num = sub_mod(r_y2, r_y1, r_mod);
                    n_den = sub_mod(r_x2, r_x1, r_mod);
                    n_state = S_DEN;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ, S_TRI: begin
                w_ua = (r_state == S_SQ) ? r_x1 : FB'(3);
                w_ub = (r_state == S_SQ) ? r_x1 : r_num;
                if (!r_wait) begin
                    w_req.start = 1'b1; n_wait = 1'b1;
                end else if (w_sts.done) begin
                    n_wait = 1'b0;
                    if (r_state == S_SQ) begin
                        n_num = w_res; n_state = S_TRI;
                    end else begin
                        n_num = add_mod(w_res, r_a, r_mod);
                        n_den = add_mod(r_y1, r_y1, r_mod);
                        n_state = S_DEN;
                    end
                end
            end
            S_DEN: begin
                n_r0 = r_mod; n_r1 = r_den; n_t0 = '0; n_t1 = FB'(1);
                if (r_den == '0) begin
                    n_rinf = 1'b1; n_x3 = '0; n_y3 = '0; n_state = S_OUT;
                end else begin
                    n_state = S_IDIV;
                end
            end
            S_IDIV: begin
                w_req.op = OP_DIV;
                w_ua = r_r1; w_ub = r_r0;
                if (r_r1 == '0) begin
                    n_state = S_ICHK;
                end else if (!r_wait) begin
                    w_req.start = 1'b1; n_wait = 1'b1;
                end else if (w_sts.done) begin
                    n_wait = 1'b0;
                    n_q  = (w_quo == r_mod) ? '0 : w_quo;
                    n_nr = w_res;
                    n_state = S_IMUL;
                end
            end
            S_IMUL: begin
                w_ua = r_q; w_ub = r_t1;
                if (!r_wait) begin
                    w_req.start = 1'b1; n_wait = 1'b1;
                end else if (w_sts.done) begin
                    n_wait = 1'b0;
                    n_t1 = sub_mod(r_t0, w_res, r_mod);
                    n_t0 = r_t1; n_r0 = r_r1; n_r1 = r_nr;
                    n_state = S_IDIV;
                end
            end
            S_ICHK: begin
                if (r_r0 != FB'(1)) begin
                    n_rinf = 1'b1; n_x3 = '0; n_y3 = '0; n_state = S_OUT;
                end else begin
                    n_state = S_LAM;
                end
            end
            S_LAM, S_LSQ: begin
                w_ua = r_num;
                w_ub = (r_state == S_LAM) ? r_t0 : r_num;
                if (!r_wait) begin
                    w_req.start = 1'b1; n_wait = 1'b1;
                end else if (w_sts.done) begin
                    n_wait = 1'b0;
                    if (r_state == S_LAM) begin
                        n_num = w_res; n_state = S_LSQ;
                    end else begin
                        n_x3 = sub_mod(sub_mod(w_res, r_x1, r_mod), r_x2, r_mod);
                        n_state = S_LY;
                    end
                end
            end
            S_LY: begin
                w_ua = r_num; w_ub = sub_mod(r_x1, r_x3, r_mod);
                if (!r_wait) begin
                    w_req.start = 1'b1; n_wait = 1'b1;
                end else if (w_sts.done) begin
                    n_wait = 1'b0;
                    n_y3 = sub_mod(w_res, r_y1, r_mod);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_mvalid || i_m_axis_tready) begin
                    n_mvalid = 1'b1;
                    n_ox = r_rinf ? '0 : r_x3;
                    n_oy = r_rinf ? '0 : r_y3;
                    n_oinf = r_rinf;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_mvalid <= 1'b0;
            r_mod    <= MOD_RST;
            r_coeff  <= COEFF_RST;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_mvalid <= n_mvalid;
            if (i_cfg_valid && i_cfg_index == REG_MODULUS) r_mod <= i_cfg_data;
            if (i_cfg_valid && i_cfg_index == REG_COEFF)   r_coeff <= i_cfg_data;
        end
        r_k <= n_k;
        r_cmd <= n_cmd; r_inf1 <= n_inf1; r_inf2 <= n_inf2;
        r_x1 <= n_x1; r_y1 <= n_y1; r_x2 <= n_x2; r_y2 <= n_y2; r_a <= n_a;
        r_num <= n_num; r_den <= n_den;
        r_r0 <= n_r0; r_r1 <= n_r1; r_t0 <= n_t0; r_t1 <= n_t1; r_q <= n_q; r_nr <= n_nr;
        r_x3 <= n_x3; r_y3 <= n_y3; r_rinf <= n_rinf;
        r_ox <= n_ox; r_oy <= n_oy; r_oinf <= n_oinf;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = {r_oy, r_ox};
    assign o_m_axis_tuser  = r_oinf;
    assign o_cfg_ready     = 1'b1;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_sts.busy)
        else $error("unit started while busy");

    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && r_oinf) |-> (r_ox == '0 && r_oy == '0))
        else $error("infinity result with nonzero coordinates");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_mvalid || i_m_axis_tready)) |=> (r_mvalid && r_state == S_IDLE))
        else $error("result not loaded");

endmodule
